@@ rtl/lfla_pkg.sv @@
// ----------------------------------------------------------------------------
// lfla_pkg
// Shared widths, codes and defaults for the linked free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfla_pkg;

  localparam int unsigned OpW          = 3;
  localparam int unsigned LinkW        = 10;
  localparam int unsigned EntriesDflt  = 512;
  localparam int unsigned ReservedDflt = 8;

  // End-of-chain marker, also the largest 10-bit reference
  localparam logic [LinkW-1:0] ListEnd = 10'h3FF;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE_ONE = 3'd1,
    OP_FREE_CHN = 3'd2,
    OP_CLAIM    = 3'd3,
    OP_RELEASE  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FCHAIN,
    S_FCH_WR,
    S_CLAIM,
    S_PUSH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/lfla_req_if.sv @@
// ----------------------------------------------------------------------------
// lfla_req_if
// Request channel: valid/ready handshake plus one request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfla_req_if;
  logic                         valid;
  logic                         ready;
  logic [lfla_pkg::OpW-1:0]     op;
  logic [lfla_pkg::LinkW-1:0]   ref_req;
  logic [lfla_pkg::LinkW-1:0]   count;
  logic [lfla_pkg::LinkW-1:0]   chain_head;

  modport source (output valid, output op, output ref_req, output count,
                  output chain_head, input ready);
  modport sink   (input valid, input op, input ref_req, input count,
                  input chain_head, output ready);
endinterface

`default_nettype wire

@@ rtl/lfla_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lfla_rsp_if
// Response channel: valid/ready handshake plus one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfla_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [lfla_pkg::LinkW-1:0]   ref_out;
  logic [lfla_pkg::LinkW-1:0]   next_head;
  logic [lfla_pkg::LinkW-1:0]   free_total;

  modport source (output valid, output status, output ref_out, output next_head,
                  output free_total, input ready);
  modport sink   (input valid, input status, input ref_out, input next_head,
                  input free_total, output ready);
endinterface

`default_nettype wire

@@ rtl/linked_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// linked_free_list_allocator
// Free list of 10-bit references kept as next-links in a link RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request beat (op, ref_req, count, chain_head); rsp_o
//   returns exactly one result beat (status, ref_out, next_head, free_total)
//   per request, in order. Beats move when valid and ready are both high.
//   One request is worked at a time; req_i.ready is high only while idle.
//   Cycles from the accept edge to the first edge that can take the result
//   (one link RAM read per cycle):
//     allocate run     : count + 2 (walks count links)
//     free chain       : L + 3 for a chain of L entries; the walk stops at the
//                        first end or out-of-range link, and a looping chain
//                        is cut after NSLOT-1 hops (NSLOT + 2)
//     claim private    : 3
//     free one, release, rejected or unknown op : 2
//   A request may be accepted while the last result still waits in the
//   output register; a stalled receiver holds the block in its final step
//   until the output register frees up.
//   Reset: after rst_ni rises a clearing pass writes the initial chain over
//   the link RAM, one entry per cycle, NSLOT = min(ENTRIES, 1023) cycles;
//   no request is accepted during the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_free_list_allocator #(
  parameter int unsigned ENTRIES  = lfla_pkg::EntriesDflt,
  parameter int unsigned RESERVED = lfla_pkg::ReservedDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfla_req_if.sink    req_i,
  lfla_rsp_if.source  rsp_o
);

  localparam int unsigned LinkW = lfla_pkg::LinkW;
  // Usable slots: 1023 is the end marker so at most 1023 references exist
  localparam int unsigned NSlot = (ENTRIES < 1023) ? ENTRIES : 1023;
  localparam int unsigned AddrW = $clog2(NSlot);

  localparam logic [LinkW-1:0] NSlotW    = LinkW'(NSlot);
  localparam logic [LinkW-1:0] InitHead  = LinkW'(RESERVED);
  localparam logic [LinkW-1:0] InitTotal = LinkW'(NSlot - RESERVED);
  localparam logic [AddrW-1:0] LastIdx   = AddrW'(NSlot - 1);
  localparam logic [LinkW-1:0] ListEnd   = lfla_pkg::ListEnd;

  lfla_pkg::state_e state_q, state_d;

  logic [AddrW-1:0] init_idx_q, init_idx_d;
  logic [LinkW-1:0] free_head_q, free_head_d;
  logic [LinkW-1:0] free_total_q, free_total_d;
  logic [LinkW-1:0] cur_q, cur_d;       // current link (walk position / tail)
  logic [LinkW-1:0] chain_q, chain_d;   // head of a chain being freed
  logic [LinkW-1:0] rem_q, rem_d;       // reads left in an allocate walk
  logic [LinkW-1:0] steps_q, steps_d;   // hops taken in a free-chain walk
  logic             rd_ok_q, rd_ok_d;   // last read address was in range

  logic             res_st_q, res_st_d;
  logic [LinkW-1:0] res_ref_q, res_ref_d;
  logic [LinkW-1:0] res_nh_q, res_nh_d;

  logic             out_v_q;
  logic             out_st_q;
  logic [LinkW-1:0] out_ref_q, out_nh_q, out_tot_q;
  logic             push;

  // RAM ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  // Link read result; out-of-range reads give the end marker
  logic [LinkW-1:0] rdv;
  assign rdv = rd_ok_q ? ram_rdata : ListEnd;

  // Shared saturating adder for the free count
  logic [LinkW-1:0] add_n;
  logic [LinkW:0]   add_sum;
  logic [LinkW-1:0] add_sat;
  assign add_sum = {1'b0, free_total_q} + {1'b0, add_n};
  assign add_sat = add_sum[LinkW] ? ListEnd : add_sum[LinkW-1:0];

  // Clearing pass data: entries in [RESERVED, NSLOT-2] link to the next one
  logic [LinkW:0]   init_nx;
  logic [LinkW-1:0] init_data;
  assign init_nx   = (LinkW+1)'(init_idx_q) + (LinkW+1)'(1);
  assign init_data = ((LinkW+1)'(init_idx_q) >= (LinkW+1)'(RESERVED) &&
                      init_nx < (LinkW+1)'(NSlot)) ? init_nx[LinkW-1:0] : ListEnd;

  lfla_ram #(
    .Width (LinkW),
    .Depth (NSlot)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == lfla_pkg::S_IDLE);
  assign push        = (state_q == lfla_pkg::S_PUSH) && (!out_v_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lfla_pkg::S_INIT;
      init_idx_q   <= '0;
      free_head_q  <= InitHead;
      free_total_q <= InitTotal;
      rd_ok_q      <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_idx_q   <= init_idx_d;
      free_head_q  <= free_head_d;
      free_total_q <= free_total_d;
      rd_ok_q      <= rd_ok_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    chain_q   <= chain_d;
    rem_q     <= rem_d;
    steps_q   <= steps_d;
    res_st_q  <= res_st_d;
    res_ref_q <= res_ref_d;
    res_nh_q  <= res_nh_d;
    if (push) begin
      out_st_q  <= res_st_q;
      out_ref_q <= res_ref_q;
      out_nh_q  <= res_nh_q;
      out_tot_q <= free_total_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    init_idx_d   = init_idx_q;
    free_head_d  = free_head_q;
    free_total_d = free_total_q;
    cur_d        = cur_q;
    chain_d      = chain_q;
    rem_d        = rem_q;
    steps_d      = steps_q;
    rd_ok_d      = 1'b0;
    res_st_d     = res_st_q;
    res_ref_d    = res_ref_q;
    res_nh_d     = res_nh_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    add_n        = '0;

    case (state_q)
      lfla_pkg::S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = init_idx_q;
        ram_wdata  = init_data;
        init_idx_d = init_idx_q + AddrW'(1);
        if (init_idx_q == LastIdx) begin
          state_d = lfla_pkg::S_IDLE;
        end
      end

      lfla_pkg::S_IDLE: begin
        if (req_i.valid) begin
          res_st_d  = 1'b0;
          res_ref_d = ListEnd;
          res_nh_d  = ListEnd;
          state_d   = lfla_pkg::S_PUSH;
          case (req_i.op)
            lfla_pkg::OP_ALLOC: begin
              if (req_i.count == '0 || req_i.count > free_total_q) begin
                res_st_d = 1'b1;
              end else begin
                res_ref_d    = free_head_q;
                free_total_d = free_total_q - req_i.count;
                rem_d        = req_i.count;
                cur_d        = free_head_q;
                ram_raddr    = free_head_q[AddrW-1:0];
                rd_ok_d      = (free_head_q < NSlotW);
                state_d      = lfla_pkg::S_ALLOC;
              end
            end
            lfla_pkg::OP_FREE_ONE: begin
              if (req_i.ref_req < NSlotW) begin
                ram_we       = 1'b1;
                ram_waddr    = req_i.ref_req[AddrW-1:0];
                ram_wdata    = free_head_q;
                free_head_d  = req_i.ref_req;
                add_n        = LinkW'(1);
                free_total_d = add_sat;
              end
            end
            lfla_pkg::OP_FREE_CHN: begin
              if (req_i.ref_req < NSlotW) begin
                chain_d   = req_i.ref_req;
                cur_d     = req_i.ref_req;
                steps_d   = '0;
                ram_raddr = req_i.ref_req[AddrW-1:0];
                rd_ok_d   = 1'b1;
                state_d   = lfla_pkg::S_FCHAIN;
              end
            end
            lfla_pkg::OP_CLAIM: begin
              if (req_i.chain_head < NSlotW) begin
                res_ref_d = req_i.chain_head;
                ram_raddr = req_i.chain_head[AddrW-1:0];
                rd_ok_d   = 1'b1;
                state_d   = lfla_pkg::S_CLAIM;
              end else begin
                res_st_d = 1'b1;
                res_nh_d = req_i.chain_head;
              end
            end
            lfla_pkg::OP_RELEASE: begin
              if (req_i.ref_req < NSlotW) begin
                ram_we    = 1'b1;
                ram_waddr = req_i.ref_req[AddrW-1:0];
                ram_wdata = req_i.chain_head;
                res_ref_d = req_i.ref_req;
                res_nh_d  = req_i.ref_req;
              end else begin
                res_ref_d = req_i.chain_head;
                res_nh_d  = req_i.chain_head;
              end
            end
            default: begin
              // unknown op: plain answer, no change
            end
          endcase
        end
      end

      // one link per cycle; the last read yields the new free head
      lfla_pkg::S_ALLOC: begin
        if (rem_q > LinkW'(1)) begin
          cur_d     = rdv;
          rem_d     = rem_q - LinkW'(1);
          ram_raddr = rdv[AddrW-1:0];
          rd_ok_d   = (rdv < NSlotW);
        end else begin
          free_head_d = rdv;
          if (cur_q < NSlotW) begin
            ram_we    = 1'b1;
            ram_waddr = cur_q[AddrW-1:0];
            ram_wdata = ListEnd;
          end
          state_d = lfla_pkg::S_PUSH;
        end
      end

      lfla_pkg::S_FCHAIN: begin
        if (rdv < NSlotW) begin
          cur_d   = rdv;
          steps_d = steps_q + LinkW'(1);
          if ((LinkW+1)'(steps_q) + (LinkW+1)'(2) < (LinkW+1)'(NSlot)) begin
            ram_raddr = rdv[AddrW-1:0];
            rd_ok_d   = 1'b1;
          end else begin
            state_d = lfla_pkg::S_FCH_WR;
          end
        end else begin
          state_d = lfla_pkg::S_FCH_WR;
        end
      end

      // splice the walked chain in front of the free list
      lfla_pkg::S_FCH_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = cur_q[AddrW-1:0];
        ram_wdata    = free_head_q;
        free_head_d  = chain_q;
        add_n        = steps_q + LinkW'(1);
        free_total_d = add_sat;
        state_d      = lfla_pkg::S_PUSH;
      end

      lfla_pkg::S_CLAIM: begin
        res_nh_d = rdv;
        state_d  = lfla_pkg::S_PUSH;
      end

      lfla_pkg::S_PUSH: begin
        if (push) begin
          state_d = lfla_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lfla_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.ref_out    = out_ref_q;
  assign rsp_o.next_head  = out_nh_q;
  assign rsp_o.free_total = out_tot_q;

endmodule

`default_nettype wire

@@ rtl/lfla_ram.sv @@
// ----------------------------------------------------------------------------
// lfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfla_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
